FILE: design/qrdmp_pkg.sv
// ----------------------------------------------------------------------------
// qrdmp_pkg: shared types and constants for QR data module placement
// Alignment coordinate table and version limits.
// ----------------------------------------------------------------------------
package qrdmp_pkg;

	localparam int MAX_VERSION_DEF  = 40;
	localparam int ALIGN_COORDS_DEF = 7;
	localparam int VER_W            = 6;
	localparam int POS_W            = 8;

	typedef logic [POS_W-1:0] pos_t;

	// alignment coordinates for a version (1-based), zero marks unused slots
	function automatic logic [55:0] align_row(input logic [VER_W-1:0] v);
		logic [55:0] r;
		r = '0;
		unique case (v)
			6'd2:  r = {8'd0,8'd0,8'd0,8'd0,8'd0,8'd18,8'd6};
			6'd3:  r = {8'd0,8'd0,8'd0,8'd0,8'd0,8'd22,8'd6};
			6'd4:  r = {8'd0,8'd0,8'd0,8'd0,8'd0,8'd26,8'd6};
			6'd5:  r = {8'd0,8'd0,8'd0,8'd0,8'd0,8'd30,8'd6};
			6'd6:  r = {8'd0,8'd0,8'd0,8'd0,8'd0,8'd34,8'd6};
			6'd7:  r = {8'd0,8'd0,8'd0,8'd0,8'd38,8'd22,8'd6};
			6'd8:  r = {8'd0,8'd0,8'd0,8'd0,8'd42,8'd24,8'd6};
			6'd9:  r = {8'd0,8'd0,8'd0,8'd0,8'd46,8'd26,8'd6};
			6'd10: r = {8'd0,8'd0,8'd0,8'd0,8'd50,8'd28,8'd6};
			6'd11: r = {8'd0,8'd0,8'd0,8'd0,8'd54,8'd30,8'd6};
			6'd12: r = {8'd0,8'd0,8'd0,8'd0,8'd58,8'd32,8'd6};
			6'd13: r = {8'd0,8'd0,8'd0,8'd0,8'd62,8'd34,8'd6};
			6'd14: r = {8'd0,8'd0,8'd0,8'd66,8'd46,8'd26,8'd6};
			6'd15: r = {8'd0,8'd0,8'd0,8'd70,8'd48,8'd26,8'd6};
			6'd16: r = {8'd0,8'd0,8'd0,8'd74,8'd50,8'd26,8'd6};
			6'd17: r = {8'd0,8'd0,8'd0,8'd78,8'd54,8'd30,8'd6};
			6'd18: r = {8'd0,8'd0,8'd0,8'd82,8'd56,8'd30,8'd6};
			6'd19: r = {8'd0,8'd0,8'd0,8'd86,8'd58,8'd30,8'd6};
			6'd20: r = {8'd0,8'd0,8'd0,8'd90,8'd62,8'd34,8'd6};
			6'd21: r = {8'd0,8'd0,8'd94,8'd72,8'd50,8'd28,8'd6};
			6'd22: r = {8'd0,8'd0,8'd98,8'd74,8'd50,8'd26,8'd6};
			6'd23: r = {8'd0,8'd0,8'd102,8'd78,8'd54,8'd30,8'd6};
			6'd24: r = {8'd0,8'd0,8'd106,8'd80,8'd54,8'd28,8'd6};
			6'd25: r = {8'd0,8'd0,8'd110,8'd84,8'd58,8'd32,8'd6};
			6'd26: r = {8'd0,8'd0,8'd114,8'd86,8'd58,8'd30,8'd6};
			6'd27: r = {8'd0,8'd0,8'd118,8'd90,8'd62,8'd34,8'd6};
			6'd28: r = {8'd0,8'd122,8'd98,8'd74,8'd50,8'd26,8'd6};
			6'd29: r = {8'd0,8'd126,8'd102,8'd78,8'd54,8'd30,8'd6};
			6'd30: r = {8'd0,8'd130,8'd104,8'd78,8'd52,8'd26,8'd6};
			6'd31: r = {8'd0,8'd134,8'd108,8'd82,8'd56,8'd30,8'd6};
			6'd32: r = {8'd0,8'd138,8'd112,8'd86,8'd60,8'd34,8'd6};
			6'd33: r = {8'd0,8'd142,8'd114,8'd86,8'd58,8'd30,8'd6};
			6'd34: r = {8'd0,8'd146,8'd118,8'd90,8'd62,8'd34,8'd6};
			6'd35: r = {8'd150,8'd126,8'd102,8'd78,8'd54,8'd30,8'd6};
			6'd36: r = {8'd154,8'd128,8'd102,8'd76,8'd50,8'd24,8'd6};
			6'd37: r = {8'd158,8'd132,8'd106,8'd80,8'd54,8'd28,8'd6};
			6'd38: r = {8'd162,8'd136,8'd110,8'd84,8'd58,8'd32,8'd6};
			6'd39: r = {8'd166,8'd138,8'd110,8'd82,8'd54,8'd26,8'd6};
			6'd40: r = {8'd170,8'd142,8'd114,8'd86,8'd58,8'd30,8'd6};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: design/qr_data_module_placement_unit.sv
// ----------------------------------------------------------------------------
// qr_data_module_placement_unit
// Places codeword bits on free QR data modules along the two-column zigzag.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_axis    in   tdata[7:0] data_byte, tuser restart
// m_axis    out  tdata {pad,symbol_full,placed,dark,column,row}, tlast last
// apb       in   register 0 symbol_version
//
// A byte is taken only in ST_IDLE, so a new one waits until all eight bits
// of the last are out. For each bit, ST_PLACE skips function modules and
// places the bit, then ST_FIND seeks the next free module and hands the
// result out. After restart, reset or a version write, the first placement
// skips function modules at bottom-right first. An m_axis stall holds the
// walker on the found module until the output register frees.
// ----------------------------------------------------------------------------
module qr_data_module_placement_unit #(
	parameter int MAX_VERSION = qrdmp_pkg::MAX_VERSION_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tuser,   // restart
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // row, column, dark, placed, symbol_full, pad[4:0]
	output logic        m_axis_tlast    // last
);
	import qrdmp_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_PLACE, ST_FIND} state_t;

	state_t           state_q;
	logic [VER_W-1:0] ver_q;
	pos_t             prc_q, row_q;
	logic             up_q, left_q, full_q;
	logic [7:0]       sr_q;
	logic [2:0]       cnt_q;
	pos_t             res_row_q, res_col_q;
	logic             res_dark_q, res_placed_q;
	logic [23:0]      out_q;
	logic             ovld_q, olast_q;

	pos_t side, col, wside;
	logic is_func, in_align, stop;
	logic [55:0] arow;
	pos_t nx_prc, nx_row;
	logic nx_up, nx_left, nx_full;
	logic take, cfg_wr, out_load;
	logic [VER_W-1:0] wv;

	assign pready = 1'b1;
	assign prdata = {26'd0, ver_q};
	assign side   = POS_W'(17) + {ver_q, 2'b00};
	assign col    = prc_q - pos_t'(left_q);
	assign arow   = align_row(ver_q);

	// alignment test on current position
	always_comb begin
		logic [ALIGN_COORDS_DEF-1:0] rv, ch;
		logic [2:0] n;
		pos_t cv, chh;
		n = '0;
		for (int i = 0; i < ALIGN_COORDS_DEF; i++) begin
			cv = arow[i*8 +: 8];
			rv[i] = (cv != '0) && (row_q + 8'd2 >= cv) && (row_q <= cv + 8'd2);
			ch[i] = (cv != '0) && (col + 8'd2 >= cv) && (col <= cv + 8'd2);
			if (cv != '0) n = n + 3'd1;
		end
		chh = pos_t'(n) - 8'd1;
		in_align = 1'b0;
		for (int v = 0; v < ALIGN_COORDS_DEF; v++)
			for (int h = 0; h < ALIGN_COORDS_DEF; h++) begin
				if (!((v == 0 && h == 0) || (h == 0 && 8'(v) >= chh) ||
				      (v == 0 && 8'(h) >= chh)) && rv[v] && ch[h])
					in_align = 1'b1;
			end
	end

	assign is_func = (row_q == 8'd6) || (col == 8'd6) || (row_q < 8'd9 && col < 8'd9) ||
		(row_q < 8'd9 && col >= side - 8'd8) || (col < 8'd9 && row_q >= side - 8'd8) ||
		in_align;

	// walker rests here: a free module, or past the end
	assign stop = full_q || !is_func;

	// one step along the zigzag
	always_comb begin
		nx_prc  = prc_q;
		nx_row  = row_q;
		nx_up   = up_q;
		nx_left = 1'b0;
		nx_full = full_q;
		if (!left_q) begin
			nx_left = 1'b1;
		end else if (up_q && row_q != '0) begin
			nx_row = row_q - 8'd1;
		end else if (!up_q && row_q + 8'd1 < side) begin
			nx_row = row_q + 8'd1;
		end else if (prc_q <= 8'd1) begin
			nx_full = 1'b1;
		end else begin
			nx_prc = (prc_q == 8'd8) ? 8'd5 : prc_q - 8'd2;
			nx_up  = !up_q;
			nx_row = up_q ? 8'd0 : side - 8'd1;
		end
	end

	assign cfg_wr  = psel && penable && pwrite && pready && paddr == 1'b0;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign take    = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = ovld_q;
	assign m_axis_tdata  = out_q;
	assign m_axis_tlast  = olast_q;
	assign wv = (pwdata[VER_W-1:0] == '0) ? VER_W'(1) :
		(pwdata[VER_W-1:0] > VER_W'(MAX_VERSION)) ? VER_W'(MAX_VERSION) : pwdata[VER_W-1:0];
	assign wside = POS_W'(17) + {wv, 2'b00};
	assign out_load = !cfg_wr && (state_q == ST_FIND) && stop && (!ovld_q || m_axis_tready);

	// walker, shifter and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; ver_q <= 6'd1; prc_q <= 8'd20; row_q <= 8'd20;
			up_q <= 1'b1; left_q <= 1'b0; full_q <= 1'b0; ovld_q <= 1'b0;
			olast_q <= 1'b0; cnt_q <= '0; sr_q <= '0; out_q <= '0;
			res_row_q <= '0; res_col_q <= '0; res_dark_q <= 1'b0; res_placed_q <= 1'b0;
		end else begin
			// result transfer out
			if (out_load) ovld_q <= 1'b1;
			else if (m_axis_tready) ovld_q <= 1'b0;
			if (out_load) begin
				olast_q <= (cnt_q == 3'd7);
				out_q   <= {5'd0, full_q, res_placed_q, res_dark_q, res_col_q, res_row_q};
			end
			if (cfg_wr) begin
				ver_q <= wv;
				prc_q <= wside - 8'd1;
				row_q <= wside - 8'd1;
				up_q <= 1'b1; left_q <= 1'b0; full_q <= 1'b0;
				state_q <= ST_IDLE;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (take) begin
							sr_q <= s_axis_tdata; cnt_q <= '0;
							state_q <= ST_PLACE;
							if (s_axis_tuser) begin
								prc_q <= side - 8'd1; row_q <= side - 8'd1;
								up_q <= 1'b1; left_q <= 1'b0; full_q <= 1'b0;
							end
						end
					end
					ST_PLACE: begin
						// skip function modules, then place the bit and step on
						if (!full_q) begin
							prc_q <= nx_prc; row_q <= nx_row; up_q <= nx_up;
							left_q <= nx_left; full_q <= nx_full;
						end
						if (stop) begin
							res_row_q    <= full_q ? '0 : row_q;
							res_col_q    <= full_q ? '0 : col;
							res_dark_q   <= !full_q && sr_q[7];
							res_placed_q <= !full_q;
							sr_q <= {sr_q[6:0], 1'b0};
							state_q <= ST_FIND;
						end
					end
					ST_FIND: begin
						// seek next free module, then hand the result out
						if (!stop) begin
							prc_q <= nx_prc; row_q <= nx_row; up_q <= nx_up;
							left_q <= nx_left; full_q <= nx_full;
						end else if (out_load) begin
							cnt_q <= cnt_q + 3'd1;
							state_q <= (cnt_q == 3'd7) ? ST_IDLE : ST_PLACE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) s_axis_tready |-> state_q == ST_IDLE)
		else $error("ready while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
		else $error("output changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		ver_q != 6'd0 && ver_q <= VER_W'(MAX_VERSION))
		else $error("version out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[17]) |-> m_axis_tdata[18])
		else $error("dropped bit without full symbol");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[23:19] == 5'd0)
		else $error("pad bits set");

endmodule

FILE: tb/sv/qr_data_module_placement_unit_test.sv
// ----------------------------------------------------------------------------
// QR data module placement testbench
// Streams codeword bytes through the placement unit under several symbol
// versions. A scoreboard tracks the zigzag walk and checks every placed
// module transfer. Both streams see random gaps and stalls.
// ----------------------------------------------------------------------------
module qr_data_module_placement_unit_test;

	timeunit 1ns;
	timeprecision 1ps;

	import qrdmp_pkg::*;

	typedef struct {
		pos_t row;
		pos_t column;
		bit   dark;
		bit   placed;
		bit   sym_full;
		bit   last;
	} module_t;

	// Zigzag walk tracker and queue of module placements still to come
	class placement_scoreboard;
		int      version;
		int      pair_col;
		int      cur_row;
		bit      going_up;
		bit      on_left;
		bit      filled;
		module_t pending[$];
		int      errors;

		function int side();
			return 17 + 4 * version;
		endfunction

		// alignment pattern hit, corners at the finders left out
		function bit in_align(int r, int c);
			logic [55:0] tab;
			int co[7];
			int n;
			tab = align_row(version[5:0]);
			n = 0;
			for (int i = 0; i < 7; i++) co[i] = int'(tab[8*i +: 8]);
			while (n < 7 && co[n] != 0) n++;
			for (int v = 0; v < n; v++)
				for (int h = 0; h < n; h++) begin
					if ((v == 0 && h == 0) || (h == 0 && v >= n - 1) ||
					    (v == 0 && h >= n - 1))
						continue;
					if (r - co[v] >= -2 && r - co[v] <= 2 &&
					    c - co[h] >= -2 && c - co[h] <= 2)
						return 1;
				end
			return 0;
		endfunction

		function bit is_reserved(int r, int c);
			int s;
			s = side();
			if (r == 6 || c == 6) return 1;
			if (r < 9 && c < 9) return 1;
			if (r < 9 && c >= s - 8) return 1;
			if (c < 9 && r >= s - 8) return 1;
			return in_align(r, c);
		endfunction

		function void step_walk();
			if (!on_left) begin
				on_left = 1;
				return;
			end
			on_left = 0;
			if (going_up && cur_row > 0) begin
				cur_row--;
				return;
			end
			if (!going_up && cur_row + 1 < side()) begin
				cur_row++;
				return;
			end
			if (pair_col <= 1) begin
				filled = 1;
				return;
			end
			pair_col -= 2;
			if (pair_col == 6) pair_col = 5;
			going_up = !going_up;
			cur_row = going_up ? side() - 1 : 0;
		endfunction

		function void seek();
			while (!filled && is_reserved(cur_row, pair_col - on_left))
				step_walk();
		endfunction

		function void restart_walk();
			pair_col = side() - 1;
			cur_row = side() - 1;
			going_up = 1;
			on_left = 0;
			filled = 0;
			seek();
		endfunction

		function void set_version(logic [31:0] value);
			int v;
			v = int'(value[5:0]);
			if (v < 1) v = 1;
			if (v > MAX_VERSION_DEF) v = MAX_VERSION_DEF;
			version = v;
			restart_walk();
		endfunction

		// accepted byte: queue its eight module placements
		function void note_byte(logic [7:0] data, logic restart);
			module_t m;
			if (restart) restart_walk();
			for (int k = 0; k < 8; k++) begin
				m = '{default: 0};
				if (!filled) begin
					m.row = pos_t'(cur_row);
					m.column = pos_t'(pair_col - on_left);
					m.dark = data[7 - k];
					m.placed = 1;
					step_walk();
					seek();
				end
				m.sym_full = filled;
				m.last = (k == 7);
				pending.push_back(m);
			end
		endfunction

		function void check_module(logic [23:0] data, logic tlast);
			module_t m;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected transfer: tdata=%h", data);
				return;
			end
			m = pending.pop_front();
			if (data[7:0] !== m.row || data[15:8] !== m.column ||
			    data[16] !== m.dark || data[17] !== m.placed ||
			    data[18] !== m.sym_full || tlast !== m.last) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: exp row %0d col %0d dark %b placed %b full %b",
						" last %b, got row %0d col %0d dark %b placed %b full %b last %b"},
						m.row, m.column, m.dark, m.placed, m.sym_full, m.last,
						data[7:0], data[15:8], data[16], data[17], data[18], tlast);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [0:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;    // data_byte
	logic        s_axis_tuser;    // restart
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;    // row, column, dark, placed, symbol_full, pad
	logic        m_axis_tlast;    // last

	placement_scoreboard sb;
	bit no_idle;

	qr_data_module_placement_unit u_top (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int gap_len();
		if (no_idle) return 0;
		return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
	endfunction

	// receiver stalls
	initial begin
		m_axis_tready = 1'b0;
		wait (arst_n);
		forever begin
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			if (gap_len() > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap_len()) @(posedge clk);
			end
		end
	end

	// result monitor
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) sb.check_module(m_axis_tdata, m_axis_tlast);
		end
	end

	task automatic reg_write(logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= '0;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_version(value);
	endtask

	task automatic send_byte(logic [7:0] data, logic restart);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tuser <= restart;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_byte(data, restart);
	endtask

	// drain all placements, then let the walker settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic random_phase(logic [31:0] ver_word, int count, int restart_odds);
		drain();
		reg_write(ver_word);
		no_idle = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < count; i++)
			send_byte(8'($urandom_range(0, 255)), $urandom_range(1, restart_odds) == 1);
		no_idle = 0;
	endtask

	initial begin
		logic [31:0] phase_ver[12];
		sb = new();
		sb.set_version(32'd1);
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		no_idle = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (5) @(posedge clk);

		// directed: bit extremes at reset version, restart, largest symbol
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b1);
		send_byte(8'h80, 1'b0);
		drain();
		reg_write(32'd40);
		send_byte(8'h01, 1'b0);
		send_byte(8'hFE, 1'b1);
		// version below range and above range clamp
		drain();
		reg_write(32'd0);
		send_byte(8'hC3, 1'b0);
		drain();
		reg_write(32'hFFFF_FFFF);
		send_byte(8'h3C, 1'b0);

		// random phases; version 1 runs past a full symbol
		phase_ver = '{32'd1, 32'd2, 32'd7, 32'd14, 32'd1, 32'd21, 32'd28,
			32'd35, 32'd40, 32'hFFFF_FFC1, 32'd6, 32'd3};
		foreach (phase_ver[p])
			random_phase(phase_ver[p], 28, (phase_ver[p][5:0] == 6'd1) ? 60 : 8);
		random_phase($urandom(), 28, 8);

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: sim.f
design/qrdmp_pkg.sv
design/qr_data_module_placement_unit.sv
tb/sv/qr_data_module_placement_unit_test.sv
